### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/mur3_pkg.sv
// Shared constants, types and helper functions for the hash engine.
// No dependencies.
package mur3_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;
    localparam int ROT_K     = 15;
    localparam int ROT_H     = 13;
    localparam int SHIFT_F1  = 16;
    localparam int SHIFT_F2  = 13;
    localparam logic [2:0] FULL_BYTES = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MIX,
        S_FIN0,
        S_FM1,
        S_FM2
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL1,
        OP_MUL2,
        OP_MIX,
        OP_FIN0,
        OP_FM1,
        OP_FM2
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
        logic last;
    } t_dp_status;

    function automatic logic [31:0] f_rotl(input logic [31:0] v, input int n);
        f_rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] f_byte_mask(input logic [2:0] nbytes);
        case (nbytes)
            3'd0: f_byte_mask = 32'h0000_0000;
            3'd1: f_byte_mask = 32'h0000_00ff;
            3'd2: f_byte_mask = 32'h0000_ffff;
            3'd3: f_byte_mask = 32'h00ff_ffff;
            default: f_byte_mask = 32'hffff_ffff;
        endcase
    endfunction

endpackage

### hw/rtl/mur3_ctrl.sv
// Sequencer for the hash engine: steps one word through the shared multiplier.
// Depends on mur3_pkg.
module mur3_ctrl import mur3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MIX;
            S_MIX: begin
                n_state = i_status.last ? S_FIN0 : S_IDLE;
            end
            S_FIN0: n_state = S_FM1;
            S_FM1:  n_state = S_FM2;
            S_FM2: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_MUL1: o_cmd.op = OP_MUL1;
            S_MUL2: o_cmd.op = OP_MUL2;
            S_MIX:  o_cmd.op = OP_MIX;
            S_FIN0: o_cmd.op = OP_FIN0;
            S_FM1:  o_cmd.op = OP_FM1;
            S_FM2: begin
                o_cmd.op       = OP_FM2;
                o_cmd.out_load = !i_status.out_busy;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

### hw/rtl/mur3_datapath.sv
// Datapath: seed register, running hash, byte count, shared multiplier, result register.
// Depends on mur3_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mur3_datapath import mur3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    input  t_dp_cmd     i_cmd,
    input  logic        i_out_ready,
    output t_dp_status  o_status,
    output logic        o_out_valid,
    output logic [31:0] o_hash_value
);

    logic [31:0] r_seed;
    logic [31:0] r_hash;
    logic [31:0] r_total;
    logic        r_key_open;
    logic        r_out_valid;
    logic [31:0] r_acc;
    logic        r_last;
    logic        r_full;
    logic [31:0] r_out;

    logic [31:0] n_hash;
    logic [31:0] n_total;
    logic        n_key_open;
    logic        n_out_valid;
    logic [31:0] n_acc;
    logic        n_last;
    logic        n_full;
    logic [31:0] n_out;

    logic [2:0]  w_nbytes;
    logic [31:0] w_mul_b;
    logic [31:0] w_prod;
    logic [31:0] w_rot;
    logic [31:0] w_fin;

    assign w_nbytes = (i_valid_bytes > FULL_BYTES) ? FULL_BYTES : i_valid_bytes;
    assign w_prod   = r_acc * w_mul_b;
    assign w_rot    = f_rotl(r_hash, ROT_H);
    assign w_fin    = r_hash ^ r_total;

    always_comb begin
        case (i_cmd.op)
            OP_MUL1: w_mul_b = MIX_C1;
            OP_MUL2: w_mul_b = MIX_C2;
            OP_FM1:  w_mul_b = FIN_M1;
            OP_FM2:  w_mul_b = FIN_M2;
            default: w_mul_b = MIX_C1;
        endcase
    end

    always_comb begin
        n_hash      = r_hash;
        n_total     = r_total;
        n_key_open  = r_key_open;
        n_out_valid = r_out_valid && !i_out_ready;
        n_acc       = r_acc;
        n_last      = r_last;
        n_full      = r_full;
        n_out       = r_out;
        case (i_cmd.op)
            OP_LOAD: begin
                n_acc      = i_key_word & f_byte_mask(w_nbytes);
                n_last     = i_last_word;
                n_full     = (w_nbytes == FULL_BYTES);
                n_key_open = 1'b1;
                if (r_key_open) begin
                    n_total = r_total + {29'd0, w_nbytes};
                end else begin
                    n_hash  = r_seed;
                    n_total = {29'd0, w_nbytes};
                end
            end
            OP_MUL1: n_acc = f_rotl(w_prod, ROT_K);
            OP_MUL2: n_hash = r_hash ^ w_prod;
            OP_MIX: begin
                if (r_full) begin
                    n_hash = w_rot + (w_rot << 2) + MIX_ADD;
                end
            end
            OP_FIN0: n_acc = w_fin ^ (w_fin >> SHIFT_F1);
            OP_FM1:  n_acc = w_prod ^ (w_prod >> SHIFT_F2);
            OP_FM2: begin
                if (i_cmd.out_load) begin
                    n_out       = w_prod ^ (w_prod >> SHIFT_F1);
                    n_out_valid = 1'b1;
                    n_key_open  = 1'b0;
                end
            end
            default: n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_hash      <= '0;
            r_total     <= '0;
            r_key_open  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            r_hash      <= n_hash;
            r_total     <= n_total;
            r_key_open  <= n_key_open;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_last <= n_last;
        r_full <= n_full;
        r_out  <= n_out;
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_status.last     = r_last;
    assign o_out_valid       = r_out_valid;
    assign o_hash_value      = r_out;

    `ASSERT_IMPL(a_no_overwrite, i_cmd.out_load, !(r_out_valid && !i_out_ready))
    `ASSERT_NEXT(a_load_opens, i_cmd.op == OP_LOAD, r_key_open)
    `ASSERT_NEXT(a_emit_closes, i_cmd.out_load, !r_key_open && r_out_valid)

endmodule

### hw/rtl/murmur3_32_stream_hash_top.sv
// Channel    Handshake                   Beat contents
// in         i_in_valid / o_in_ready     i_key_word, i_valid_bytes, i_last_word
// out        o_out_valid / i_out_ready   o_hash_value
// cfg        i_cfg_wr_en                 i_cfg_wr_data (seed)
//
// A word is accepted, then steps through MUL1 and MUL2 on the one shared
// 32x32 multiplier, then MIX. A last word adds FIN0, FM1 and FM2 to finalize.
// Reset is synchronous, active low; it clears seed, hash, count and valids.
// The result register lets the next key start while a hash waits; a second
// finished hash holds in the last finalizer step until the first is taken.
module murmur3_32_stream_hash_top import mur3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_hash_value
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    mur3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mur3_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_key_word    (i_key_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .i_cmd         (w_cmd),
        .i_out_ready   (i_out_ready),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_hash_value  (o_hash_value)
    );

endmodule
